// ===== rtl/cpa_pkg.sv =====
// shared constants, types and helpers for the channel priority arbiter
`timescale 1ns / 1ps

package cpa_pkg;

  // user population and the slots that can take part
  localparam int NumUsers    = 8;
  localparam int SlotLimit   = 8;
  localparam int ActiveSlots = (NumUsers < SlotLimit) ? NumUsers : SlotLimit;

  // field widths
  localparam int UserW  = 3;
  localparam int RankW  = 2;
  localparam int MaskW  = 8;
  localparam int PrioW  = 16;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;
  localparam int TDataW = 8;

  // input kinds
  localparam logic KindRequest = 1'b0;
  localparam logic KindDone    = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic RegEnable = 1'b0;
  localparam logic RegPrio   = 1'b1;

  // priority codes
  localparam logic [RankW-1:0] PrioHigh  = 2'd2;
  localparam logic [RankW-1:0] PrioAlias = 2'd3;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StFinish = 3'b100
  } state_e;

  // priority rank of one user, code three counts as high
  function automatic logic [RankW-1:0] rank_of(input logic [PrioW-1:0] codes,
                                               input logic [UserW-1:0] user);
    logic [RankW-1:0] code;
    code = codes[{user, 1'b0} +: RankW];
    return (code == PrioAlias) ? PrioHigh : code;
  endfunction

endpackage

// ===== rtl/channel_priority_arbiter_unit.sv =====
// channel priority arbiter: request/done stream in, grant status stream out
`timescale 1ns / 1ps

// Arbitrates one shared channel among the registered users. Each input transfer is a
// request (tuser 0, user index in tdata[2:0]) or a job-done report (tuser 1). Every input
// transfer yields exactly one output transfer carrying grant_valid, the current holder and
// the busy flag. When the channel is idle and users wait, a sequencer walks the user slots
// one per cycle through a single rank comparator, keeping the highest priority waiter
// (lowest index on ties) and passing over the user that just finished unless it waits
// alone. An item that can grant goes through accept, one scan step per slot, then commit;
// an ignored request, or a request while the channel is busy, goes from accept straight to
// commit without a scan. The input side is ready only in the idle state; the
// output register lets the next item be accepted while a result waits, and the commit
// cycle holds while that register is still full. Registers: enable mask at byte address 0,
// priority codes (two bits per user) at byte address 4; write only while the block is idle.
module channel_priority_arbiter_unit
  import cpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request / done stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TDataW-1:0] s_axis_tdata,   // [2:0] user_index, [7:3] zero
  input  logic              s_axis_tuser,   // [0] kind
  // grant status stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TDataW-1:0] m_axis_tdata,   // [0] grant_valid, [3:1] grant_user,
                                            // [4] busy_res, [7:5] zero
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  // configuration registers
  logic [MaskW-1:0] enable_q, enable_d;
  logic [PrioW-1:0] prio_q, prio_d;

  // arbiter state
  logic [MaskW-1:0] waiting_q, waiting_d;
  logic             busy_q, busy_d;
  logic [UserW-1:0] holder_q, holder_d;

  // sequencer and scan accumulators
  state_e           state_q, state_d;
  logic [UserW-1:0] idx_q, idx_d;
  logic [1:0]       cnt_q, cnt_d;       // live waiters, saturates at two
  logic [UserW-1:0] first_q, first_d;   // lowest live waiter
  logic             found_q, found_d;
  logic [UserW-1:0] best_q, best_d;
  logic [RankW-1:0] best_rank_q, best_rank_d;
  logic             skip_v_q, skip_v_d;
  logic [UserW-1:0] skip_q, skip_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [TDataW-1:0] out_data_q, out_data_d;

  logic             cfg_write;
  logic             in_xfer;
  logic             out_free;
  logic [UserW-1:0] in_user;
  logic             req_ok;
  logic             live;
  logic [RankW-1:0] cur_rank;
  logic [UserW-1:0] pick;
  logic             grant;
  logic             busy_new;
  logic [UserW-1:0] holder_new;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == RegPrio) ? DataW'(prio_q) : DataW'(enable_q);

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_user       = s_axis_tdata[UserW-1:0];
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // registered requester with a slot of its own
  assign req_ok = (s_axis_tuser == KindRequest) && (32'(in_user) < ActiveSlots)
                  && enable_q[in_user];

  // the shared comparator looks at one slot per cycle
  assign live     = waiting_q[idx_q] && enable_q[idx_q];
  assign cur_rank = rank_of(prio_q, idx_q);

  // a lone waiter wins even if it was skipped
  assign pick       = (cnt_q == 2'd1) ? first_q : best_q;
  assign grant      = (cnt_q != 2'd0);
  assign busy_new   = grant ? 1'b1 : busy_q;
  assign holder_new = grant ? pick : holder_q;

  always_comb begin
    enable_d    = enable_q;
    prio_d      = prio_q;
    waiting_d   = waiting_q;
    busy_d      = busy_q;
    holder_d    = holder_q;
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    found_d     = found_q;
    best_d      = best_q;
    best_rank_d = best_rank_q;
    skip_v_d    = skip_v_q;
    skip_d      = skip_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_write) begin
      case (paddr[2])
        RegEnable: enable_d = pwdata[MaskW-1:0];
        RegPrio:   prio_d   = pwdata[PrioW-1:0];
        default:   enable_d = enable_q;
      endcase
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          idx_d    = '0;
          cnt_d    = 2'd0;
          found_d  = 1'b0;
          skip_v_d = 1'b0;
          skip_d   = holder_q;
          if (s_axis_tuser == KindDone) begin
            // release the channel and pass over the one that just finished
            busy_d   = 1'b0;
            skip_v_d = busy_q;
            state_d  = StScan;
          end else if (req_ok) begin
            waiting_d[in_user] = 1'b1;
            state_d = busy_q ? StFinish : StScan;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StScan: begin
        if (live) begin
          if (cnt_q == 2'd0) begin
            first_d = idx_q;
          end
          if (cnt_q != 2'd2) begin
            cnt_d = cnt_q + 2'd1;
          end
          if (!(skip_v_q && (idx_q == skip_q))) begin
            if (!found_q || (cur_rank > best_rank_q)) begin
              best_d      = idx_q;
              best_rank_d = cur_rank;
              found_d     = 1'b1;
            end
          end
        end
        if (idx_q == UserW'(ActiveSlots - 1)) begin
          state_d = StFinish;
        end else begin
          idx_d = idx_q + UserW'(1);
        end
      end
      StFinish: begin
        // commit only once the result has somewhere to go
        if (out_free) begin
          if (grant) begin
            waiting_d[pick] = 1'b0;
          end
          busy_d      = busy_new;
          holder_d    = holder_new;
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, busy_new, busy_new ? holder_new : UserW'(0), grant};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= '0;
      prio_q      <= '0;
      waiting_q   <= '0;
      busy_q      <= 1'b0;
      holder_q    <= '0;
      state_q     <= StIdle;
      idx_q       <= '0;
      cnt_q       <= 2'd0;
      found_q     <= 1'b0;
      skip_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      enable_q    <= enable_d;
      prio_q      <= prio_d;
      waiting_q   <= waiting_d;
      busy_q      <= busy_d;
      holder_q    <= holder_d;
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      skip_v_q    <= skip_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // scan payload, no reset needed
  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    best_q      <= best_d;
    best_rank_q <= best_rank_d;
    skip_q      <= skip_d;
    out_data_q  <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  // two or more live waiters always leave a candidate after the skip
  a_candidate_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && cnt_q == 2'd2) |-> found_q)
    else $error("several waiters but no candidate picked");

  // a committed grant leaves the channel held by the picked user
  a_grant_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && out_free && grant) |=> (busy_q && holder_q == $past(pick)))
    else $error("grant did not take the channel");

  // the new holder no longer waits
  a_holder_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> !waiting_q[holder_q])
    else $error("holder still flagged as waiting");
`endif

endmodule

// ===== bench/tb_channel_priority_arbiter_unit.sv =====
// testbench for the channel priority arbiter: directed and random request/done traffic
`timescale 1ns / 1ps

module tb_channel_priority_arbiter_unit;
  import cpa_pkg::*;

  // priority codes below high, named locally
  localparam logic [RankW-1:0] PrioLow    = 2'd0;
  localparam logic [RankW-1:0] PrioNormal = 2'd1;

  // register byte addresses
  localparam logic [AddrW-1:0] AddrEnable = {RegEnable, 2'b00};
  localparam logic [AddrW-1:0] AddrPrio   = {RegPrio, 2'b00};

  localparam int MaxGap     = 15;
  localparam int DrainCycles = 16;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic             grant;
    logic [UserW-1:0] user;
    logic             busy;
  } grant_status_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TDataW-1:0] s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b1;
  logic [TDataW-1:0] m_axis_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  channel_priority_arbiter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // arbiter state mirrored by the predictor
  logic [MaskW-1:0] enable_mask = '0;
  logic [PrioW-1:0] prio_codes = '0;
  logic [MaskW-1:0] pend_mask = '0;
  logic             chan_busy = 1'b0;
  logic [UserW-1:0] holder = '0;

  grant_status_t expected_status_q[$];
  int            mismatches = 0;
  bit            gaps_on = 1'b1;

  // grant the idle channel to the best live waiter, passing over skip_user
  // unless it waits alone
  function automatic logic grant_idle_channel(input logic skip_ok,
                                              input logic [UserW-1:0] skip_user);
    logic [MaskW-1:0] live;
    int               n_live;
    int               pick;
    logic             found;
    logic [RankW-1:0] best;
    logic [RankW-1:0] r;
    if (chan_busy) return 1'b0;
    live   = pend_mask & enable_mask;
    n_live = $countones(live);
    if (n_live == 0) return 1'b0;
    found = 1'b0;
    pick  = 0;
    best  = PrioLow;
    for (int u = 0; u < ActiveSlots; u++) begin
      if (!live[u]) continue;
      if (n_live > 1 && skip_ok && u == skip_user) continue;
      r = prio_codes[2*u +: RankW];
      if (r == PrioAlias) r = PrioHigh;
      if (!found || r > best) begin
        pick  = u;
        best  = r;
        found = 1'b1;
      end
    end
    if (!found) return 1'b0;
    pend_mask[pick] = 1'b0;
    chan_busy       = 1'b1;
    holder          = pick[UserW-1:0];
    return 1'b1;
  endfunction

  function automatic grant_status_t predict_grant(input logic kind,
                                                  input logic [UserW-1:0] user);
    grant_status_t st;
    logic          had_holder;
    st.grant = 1'b0;
    if (kind == KindRequest) begin
      if (user < ActiveSlots && enable_mask[user]) begin
        pend_mask[user] = 1'b1;
        st.grant = grant_idle_channel(1'b0, '0);
      end
    end else begin
      had_holder = chan_busy;
      chan_busy  = 1'b0;
      st.grant   = grant_idle_channel(had_holder, holder);
    end
    st.user = chan_busy ? holder : '0;
    st.busy = chan_busy;
    return st;
  endfunction

  // one input transfer; returns at the accepting edge with tvalid still high,
  // the caller either sends again or calls stop_input in the same step
  task automatic send_item(input logic kind, input logic [UserW-1:0] user);
    int gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDataW-UserW){1'b0}}, user};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_status_q.push_back(predict_grant(kind, user));
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
  endtask

  // wait until every expected status came back, then let the block go idle
  task automatic settle();
    stop_input();
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == AddrEnable) enable_mask = value[MaskW-1:0];
    else prio_codes = value[PrioW-1:0];
  endtask

  // status checker and receiver stalls
  always @(posedge clk_i) begin
    static int stall_left = 0;
    grant_status_t got;
    grant_status_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.grant = m_axis_tdata[0];
        got.user  = m_axis_tdata[3:1];
        got.busy  = m_axis_tdata[4];
        if (expected_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: unexpected status transfer grant=%0d user=%0d busy=%0d",
                     $realtime, got.grant, got.user, got.busy);
        end else begin
          want = expected_status_q.pop_front();
          if (got.grant !== want.grant || got.user !== want.user ||
              got.busy !== want.busy) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: mismatch exp grant=%0d user=%0d busy=%0d, got %0d %0d %0d",
                       $realtime, want.grant, want.user, want.busy,
                       got.grant, got.user, got.busy);
          end
        end
        stall_left = gaps_on ? $urandom_range(0, MaxGap) : 0;
        m_axis_tready <= (stall_left == 0);
      end else if (!m_axis_tready) begin
        if (stall_left > 0) stall_left--;
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  // nothing is registered after reset, so nothing is granted
  task automatic test_unregistered();
    send_item(KindRequest, 3'd0);
    send_item(KindRequest, 3'd7);
    send_item(KindDone, 3'd7);
    send_item(KindDone, 3'd0);
    settle();
  endtask

  // ranks, alias code, lowest index on ties, skipping the finished user
  task automatic test_priority_and_skip();
    // users 0..7: low normal high alias low high normal alias
    write_reg(AddrEnable, 32'h0000_00FF);
    write_reg(AddrPrio, {16'h0, PrioAlias, PrioNormal, PrioHigh, PrioLow,
                         PrioAlias, PrioHigh, PrioNormal, PrioLow});
    send_item(KindRequest, 3'd4);
    send_item(KindRequest, 3'd0);
    send_item(KindRequest, 3'd1);
    send_item(KindRequest, 3'd4);
    send_item(KindRequest, 3'd3);
    send_item(KindDone, 3'd0);
    send_item(KindRequest, 3'd2);
    send_item(KindDone, 3'd0);
    send_item(KindRequest, 3'd2);
    send_item(KindDone, 3'd0);
    send_item(KindDone, 3'd0);
    send_item(KindDone, 3'd0);
    send_item(KindDone, 3'd0);
    // the holder is also the lone waiter and gets the channel again
    send_item(KindRequest, 3'd4);
    send_item(KindDone, 3'd0);
    send_item(KindDone, 3'd0);
    settle();
  endtask

  // waiters whose registration is withdrawn keep their flags but are passed over
  task automatic test_registration_withdrawn();
    send_item(KindRequest, 3'd5);
    send_item(KindRequest, 3'd6);
    send_item(KindRequest, 3'd7);
    settle();
    write_reg(AddrEnable, 32'h0000_003F);
    send_item(KindDone, 3'd0);
    send_item(KindRequest, 3'd0);
    settle();
    write_reg(AddrEnable, 32'h0000_00FF);
    send_item(KindDone, 3'd0);
    send_item(KindDone, 3'd0);
    settle();
  endtask

  // random traffic under one register setting; requests mostly from registered users
  task automatic test_random_phase(input logic [MaskW-1:0] mask,
                                   input logic [PrioW-1:0] codes, input int n_items);
    logic             kind;
    logic [UserW-1:0] user;
    write_reg(AddrEnable, {24'h0, mask});
    write_reg(AddrPrio, {16'h0, codes});
    for (int i = 0; i < n_items; i++) begin
      kind = ($urandom_range(0, 99) < 35) ? KindDone : KindRequest;
      user = UserW'($urandom_range(0, 7));
      if (kind == KindRequest && mask != '0 && $urandom_range(0, 99) < 85)
        while (!mask[user]) user = UserW'($urandom_range(0, 7));
      send_item(kind, user);
    end
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unregistered();
    test_priority_and_skip();
    test_registration_withdrawn();
    for (int phase = 0; phase < 10; phase++) begin
      gaps_on = (phase % 3 != 2);
      case (phase)
        0: test_random_phase(8'hFF, 16'h0000, 72);
        1: test_random_phase(8'hFF, 16'hFFFF, 72);
        2: test_random_phase(8'h00, 16'h5555, 16);
        3: test_random_phase(8'h81, 16'hAAAA, 72);
        default: test_random_phase(MaskW'($urandom_range(1, 255)),
                                   PrioW'($urandom_range(0, 65535)), 80);
      endcase
    end
    gaps_on = 1'b1;
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
